// ----- design/sdeq_pkg.sv -----
// Shared types, constants and helpers for the sortable double-ended queue.
// Used by sdeq_seq and the top level sortable_double_ended_queue.
package sdeq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Command codes
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_SORT       = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] popped_value;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [CNT_W-1:0]         item_count;
    } t_out_word;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT_PRIME,
        S_SORT_STEP,
        S_SORT_END,
        S_GET_FRONT,
        S_TAKE_FRONT,
        S_TAKE_BACK
    } t_state;

    // Physical slot of a logical position, wrapping around the circular store
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                              input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(DEPTH)) begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ----- design/sdeq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register one read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/sdeq_seq.sv -----
// Command sequencer: keeps front index, count and cached end values, drives the
// entry RAM and runs the bubble sort through one shared signed comparator.
// Depends on sdeq_pkg.
module sdeq_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  sdeq_pkg::t_in_word           i_word,
    input  logic [sdeq_pkg::DATA_W-1:0]  i_rd_data,
    output logic                         o_busy,
    output sdeq_pkg::t_ram_req           o_ram_req,
    output logic                         o_emit,
    output sdeq_pkg::t_out_word          o_result
);

    localparam int IDX_W  = sdeq_pkg::IDX_W;
    localparam int CNT_W  = sdeq_pkg::CNT_W;
    localparam int DATA_W = sdeq_pkg::DATA_W;

    sdeq_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0]         r_front, n_front;
    logic [CNT_W-1:0]         r_occ, n_occ;
    logic signed [DATA_W-1:0] r_front_val, n_front_val;
    logic signed [DATA_W-1:0] r_back_val, n_back_val;
    logic signed [DATA_W-1:0] r_popped, n_popped;
    logic signed [DATA_W-1:0] r_carry, n_carry;
    logic [IDX_W-1:0]         r_pos, n_pos;
    logic [IDX_W-1:0]         r_last, n_last;
    logic                     r_swapped, n_swapped;
    logic                     r_get_back, n_get_back;

    logic [CNT_W-1:0]         occ_m1;
    logic [CNT_W-1:0]         occ_m2;
    logic signed [DATA_W-1:0] rd_val;
    logic                     carry_lt;
    logic [1:0]               res_status;

    assign occ_m1   = r_occ - CNT_W'(1);
    assign occ_m2   = r_occ - CNT_W'(2);
    assign rd_val   = $signed(i_rd_data);
    // Shared compare unit for the sort walk
    assign carry_lt = r_carry < rd_val;

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sdeq_pkg::S_IDLE;
            r_front    <= '0;
            r_occ      <= '0;
            r_swapped  <= 1'b0;
            r_get_back <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_front    <= n_front;
            r_occ      <= n_occ;
            r_swapped  <= n_swapped;
            r_get_back <= n_get_back;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_front_val <= n_front_val;
        r_back_val  <= n_back_val;
        r_popped    <= n_popped;
        r_carry     <= n_carry;
        r_pos       <= n_pos;
        r_last      <= n_last;
    end

    // Next state, RAM requests and result emission
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_occ       = r_occ;
        n_front_val = r_front_val;
        n_back_val  = r_back_val;
        n_popped    = r_popped;
        n_carry     = r_carry;
        n_pos       = r_pos;
        n_last      = r_last;
        n_swapped   = r_swapped;
        n_get_back  = r_get_back;
        o_ram_req   = '0;
        o_emit      = 1'b0;
        res_status  = sdeq_pkg::ST_OK;

        case (r_state)
            sdeq_pkg::S_IDLE: begin
                if (i_start) begin
                    n_popped = '0;
                    case (i_word.cmd)
                        sdeq_pkg::CMD_PUSH_FRONT: begin
                            o_emit = 1'b1;
                            if (r_occ == CNT_W'(sdeq_pkg::DEPTH)) begin
                                res_status = sdeq_pkg::ST_FULL;
                            end else begin
                                n_front         = sdeq_pkg::slot(r_front,
                                                      IDX_W'(sdeq_pkg::DEPTH - 1));
                                o_ram_req.we    = 1'b1;
                                o_ram_req.waddr = n_front;
                                o_ram_req.wdata = i_word.value;
                                n_front_val     = i_word.value;
                                if (r_occ == '0) begin
                                    n_back_val = i_word.value;
                                end
                                n_occ = r_occ + CNT_W'(1);
                            end
                        end
                        sdeq_pkg::CMD_PUSH_BACK: begin
                            o_emit = 1'b1;
                            if (r_occ == CNT_W'(sdeq_pkg::DEPTH)) begin
                                res_status = sdeq_pkg::ST_FULL;
                            end else begin
                                o_ram_req.we    = 1'b1;
                                o_ram_req.waddr = sdeq_pkg::slot(r_front,
                                                                 r_occ[IDX_W-1:0]);
                                o_ram_req.wdata = i_word.value;
                                n_back_val      = i_word.value;
                                if (r_occ == '0) begin
                                    n_front_val = i_word.value;
                                end
                                n_occ = r_occ + CNT_W'(1);
                            end
                        end
                        sdeq_pkg::CMD_POP_FRONT: begin
                            if (r_occ == '0) begin
                                o_emit     = 1'b1;
                                res_status = sdeq_pkg::ST_EMPTY;
                            end else begin
                                n_popped = r_front_val;
                                n_front  = sdeq_pkg::slot(r_front, IDX_W'(1));
                                n_occ    = occ_m1;
                                if (r_occ == CNT_W'(1)) begin
                                    o_emit = 1'b1;
                                end else begin
                                    // Fetch the new front entry
                                    o_ram_req.raddr = n_front;
                                    n_get_back      = 1'b0;
                                    n_state         = sdeq_pkg::S_TAKE_FRONT;
                                end
                            end
                        end
                        sdeq_pkg::CMD_POP_BACK: begin
                            if (r_occ == '0) begin
                                o_emit     = 1'b1;
                                res_status = sdeq_pkg::ST_EMPTY;
                            end else begin
                                n_popped = r_back_val;
                                n_occ    = occ_m1;
                                if (r_occ == CNT_W'(1)) begin
                                    o_emit = 1'b1;
                                end else begin
                                    // Fetch the new back entry
                                    o_ram_req.raddr = sdeq_pkg::slot(r_front,
                                                                     occ_m2[IDX_W-1:0]);
                                    n_state         = sdeq_pkg::S_TAKE_BACK;
                                end
                            end
                        end
                        sdeq_pkg::CMD_SORT: begin
                            if (r_occ <= CNT_W'(1)) begin
                                o_emit = 1'b1;
                            end else begin
                                o_ram_req.raddr = r_front;
                                n_last          = occ_m1[IDX_W-1:0];
                                n_swapped       = 1'b0;
                                n_state         = sdeq_pkg::S_SORT_PRIME;
                            end
                        end
                        default: begin
                            o_emit = 1'b1;
                        end
                    endcase
                end
            end
            sdeq_pkg::S_SORT_PRIME: begin
                // Load the first entry of the pass as the carried word
                n_carry         = rd_val;
                n_pos           = IDX_W'(1);
                o_ram_req.raddr = sdeq_pkg::slot(r_front, IDX_W'(1));
                n_state         = sdeq_pkg::S_SORT_STEP;
            end
            sdeq_pkg::S_SORT_STEP: begin
                // Keep the smaller word moving toward the back
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = sdeq_pkg::slot(r_front, r_pos - IDX_W'(1));
                if (carry_lt) begin
                    o_ram_req.wdata = rd_val;
                    n_swapped       = 1'b1;
                end else begin
                    o_ram_req.wdata = r_carry;
                    n_carry         = rd_val;
                end
                if (r_pos == r_last) begin
                    n_state = sdeq_pkg::S_SORT_END;
                end else begin
                    n_pos           = r_pos + IDX_W'(1);
                    o_ram_req.raddr = sdeq_pkg::slot(r_front, r_pos + IDX_W'(1));
                end
            end
            sdeq_pkg::S_SORT_END: begin
                // Drop the carried word into the last place of the pass
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = sdeq_pkg::slot(r_front, r_last);
                o_ram_req.wdata = r_carry;
                if (!r_swapped || r_last == IDX_W'(1)) begin
                    n_get_back = 1'b1;
                    n_state    = sdeq_pkg::S_GET_FRONT;
                end else begin
                    n_last          = r_last - IDX_W'(1);
                    n_swapped       = 1'b0;
                    o_ram_req.raddr = r_front;
                    n_state         = sdeq_pkg::S_SORT_PRIME;
                end
            end
            sdeq_pkg::S_GET_FRONT: begin
                o_ram_req.raddr = r_front;
                n_state         = sdeq_pkg::S_TAKE_FRONT;
            end
            sdeq_pkg::S_TAKE_FRONT: begin
                n_front_val = rd_val;
                if (r_get_back) begin
                    o_ram_req.raddr = sdeq_pkg::slot(r_front, occ_m1[IDX_W-1:0]);
                    n_state         = sdeq_pkg::S_TAKE_BACK;
                end else begin
                    o_emit  = 1'b1;
                    n_state = sdeq_pkg::S_IDLE;
                end
            end
            sdeq_pkg::S_TAKE_BACK: begin
                n_back_val = rd_val;
                o_emit     = 1'b1;
                n_state    = sdeq_pkg::S_IDLE;
            end
            default: begin
                n_state = sdeq_pkg::S_IDLE;
            end
        endcase
    end

    // Build the result word from the state after the command
    always_comb begin
        o_result.status       = res_status;
        o_result.popped_value = n_popped;
        o_result.front_value  = (n_occ == '0) ? '0 : n_front_val;
        o_result.back_value   = (n_occ == '0) ? '0 : n_back_val;
        o_result.item_count   = n_occ;
    end

    assign o_busy = (r_state != sdeq_pkg::S_IDLE);

endmodule

// ----- design/sortable_double_ended_queue.sv -----
// Sortable double-ended queue of signed 32-bit words, top level.
// Depends on sdeq_pkg, sdeq_ram and sdeq_seq.
//
// Usage: the input channel (i_in_valid, o_in_stall, i_in_word) carries a command
// and a value; the output channel (o_out_valid, i_out_stall, o_out_word) returns
// one result word per command: status, popped value, front and back values and
// the item count after the command.
// Flow: push, pop on empty, sort of at most one item and unused codes give
// their result in the cycle after acceptance and can be accepted every cycle
// while no result word waits under i_out_stall. A pop that leaves the queue
// non-empty first reads the new end entry from the entry RAM, which has a
// single read port and registered read data. A sort of n items walks bubble
// passes through one signed comparator, one entry per cycle, then rereads both
// ends; it stops early when a pass makes no swap.
// o_in_stall is high while a command is in progress and while a result word
// waits under i_out_stall; the result register holds until taken.
// Reset (synchronous, active low) empties the queue; entry contents are kept
// but never read before being written.
module sortable_double_ended_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sdeq_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sdeq_pkg::t_out_word  o_out_word
);

    logic                         busy;
    logic                         accept;
    logic                         emit;
    sdeq_pkg::t_ram_req           ram_req;
    sdeq_pkg::t_out_word          result;
    logic [sdeq_pkg::DATA_W-1:0]  rd_data;
    logic                         r_out_valid;
    sdeq_pkg::t_out_word          r_out_word;

    // Hold off input while busy or while the result slot cannot drain
    assign o_in_stall = busy || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    sdeq_ram #(
        .WIDTH (sdeq_pkg::DATA_W),
        .DEPTH (sdeq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

    sdeq_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_word    (i_in_word),
        .i_rd_data (rd_data),
        .o_busy    (busy),
        .o_ram_req (ram_req),
        .o_emit    (emit),
        .o_result  (result)
    );

    // Result register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A new result never overwrites a word still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(emit && r_out_valid && i_out_stall))
        else $error("result emitted while output word still stalled");

    // A dropped push only happens on a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && result.status == sdeq_pkg::ST_FULL)
        |-> (result.item_count == sdeq_pkg::CNT_W'(sdeq_pkg::DEPTH)))
        else $error("full status with queue not full");

    // Count never exceeds the store depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.item_count <= sdeq_pkg::CNT_W'(sdeq_pkg::DEPTH)))
        else $error("item count beyond depth");

    // An accepted command either emits its result at once or leaves the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !emit) |=> busy)
        else $error("command accepted without result or work in progress");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for sortable_double_ended_queue: directed edge cases,
// biased random traffic, output back-pressure and a sender pause.
// Depends on sdeq_pkg and the sortable_double_ended_queue RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Command codes the block ignores
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 1150;
    localparam int SEGMENT_LEN  = 100;
    localparam int SETTLE_CYCLES = 200;

    logic                rst_n;
    logic                clk = 1'b0;
    logic                in_valid;
    logic                in_stall;
    sdeq_pkg::t_in_word  in_word;
    logic                out_valid;
    logic                out_stall;
    sdeq_pkg::t_out_word out_word;

    // Shadow copy of the queue contents
    logic signed [sdeq_pkg::DATA_W-1:0] shadow_store [sdeq_pkg::DEPTH];
    int shadow_head;
    int shadow_count;

    sdeq_pkg::t_out_word pending_results [$];

    int  mismatch_count;
    int  checked_count;
    int  cycle_count;
    bit  tx_idle;
    bit  rx_idle;
    int  rx_hold_len;

    sortable_double_ended_queue DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always #5 clk = ~clk;

    // Apply one command to the shadow queue and return the word it should produce
    function automatic sdeq_pkg::t_out_word shadow_apply(input sdeq_pkg::t_in_word w);
        sdeq_pkg::t_out_word r;
        logic signed [sdeq_pkg::DATA_W-1:0] line [sdeq_pkg::DEPTH];
        logic signed [sdeq_pkg::DATA_W-1:0] v;
        int j;
        r = '0;
        r.status = sdeq_pkg::ST_OK;
        case (w.cmd)
            sdeq_pkg::CMD_PUSH_FRONT: begin
                if (shadow_count >= sdeq_pkg::DEPTH) begin
                    r.status = sdeq_pkg::ST_FULL;
                end else begin
                    shadow_head = (shadow_head + sdeq_pkg::DEPTH - 1) % sdeq_pkg::DEPTH;
                    shadow_store[shadow_head] = w.value;
                    shadow_count++;
                end
            end
            sdeq_pkg::CMD_PUSH_BACK: begin
                if (shadow_count >= sdeq_pkg::DEPTH) begin
                    r.status = sdeq_pkg::ST_FULL;
                end else begin
                    shadow_store[(shadow_head + shadow_count) % sdeq_pkg::DEPTH] = w.value;
                    shadow_count++;
                end
            end
            sdeq_pkg::CMD_POP_FRONT: begin
                if (shadow_count == 0) begin
                    r.status = sdeq_pkg::ST_EMPTY;
                end else begin
                    r.popped_value = shadow_store[shadow_head];
                    shadow_head = (shadow_head + 1) % sdeq_pkg::DEPTH;
                    shadow_count--;
                end
            end
            sdeq_pkg::CMD_POP_BACK: begin
                if (shadow_count == 0) begin
                    r.status = sdeq_pkg::ST_EMPTY;
                end else begin
                    r.popped_value =
                        shadow_store[(shadow_head + shadow_count - 1) % sdeq_pkg::DEPTH];
                    shadow_count--;
                end
            end
            sdeq_pkg::CMD_SORT: begin
                // insertion sort, largest first, on signed values
                for (int i = 0; i < shadow_count; i++) begin
                    line[i] = shadow_store[(shadow_head + i) % sdeq_pkg::DEPTH];
                end
                for (int i = 1; i < shadow_count; i++) begin
                    v = line[i];
                    j = i;
                    while (j > 0 && v > line[j-1]) begin
                        line[j] = line[j-1];
                        j--;
                    end
                    line[j] = v;
                end
                for (int i = 0; i < shadow_count; i++) begin
                    shadow_store[(shadow_head + i) % sdeq_pkg::DEPTH] = line[i];
                end
            end
            default: begin
            end
        endcase
        if (shadow_count > 0) begin
            r.front_value = shadow_store[shadow_head];
            r.back_value  = shadow_store[(shadow_head + shadow_count - 1) % sdeq_pkg::DEPTH];
        end
        r.item_count = sdeq_pkg::CNT_W'(shadow_count);
        return r;
    endfunction

    // Half full-range values, the rest extremes and a small pool that repeats
    function automatic logic signed [sdeq_pkg::DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
            3, 4: return $signed(32'($urandom_range(0, 6))) - 32'sd3;
            default: return $signed(32'($urandom));
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        $display("MISMATCH result %0d %s: expected %h got %h",
                 checked_count, field, want, got);
    endtask

    // Offer one word after an optional idle gap and hold it until accepted
    task automatic send_word(input logic [2:0] cmd,
                             input logic signed [sdeq_pkg::DATA_W-1:0] val);
        sdeq_pkg::t_in_word w;
        int gap;
        w.cmd   = cmd;
        w.value = val;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        pending_results.insert(pending_results.size(), shadow_apply(w));
    endtask

    // Drop valid and hold until every pending result is back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic test_directed_edges();
        send_word(sdeq_pkg::CMD_POP_FRONT, 32'sd0);
        send_word(sdeq_pkg::CMD_POP_BACK, -32'sd1);
        send_word(sdeq_pkg::CMD_SORT, 32'sd0);
        send_word(CMD_SPARE_A, 32'sh5555_5555);
        send_word(sdeq_pkg::CMD_PUSH_BACK, 32'sh8000_0000);
        send_word(sdeq_pkg::CMD_SORT, 32'sd0);
        send_word(sdeq_pkg::CMD_PUSH_FRONT, 32'sh7fff_ffff);
        send_word(CMD_SPARE_B, 32'shaaaa_aaaa);
        send_word(CMD_SPARE_C, -32'sd1);
        // fill to the top, with repeated values mixed in
        for (int k = 0; k < sdeq_pkg::DEPTH - 2; k++) begin
            send_word(k[0] ? sdeq_pkg::CMD_PUSH_BACK : sdeq_pkg::CMD_PUSH_FRONT,
                      (k == 1) ? -32'sd1 : (k == 2) ? 32'sd0 :
                      (k % 4 == 0) ? 32'sd7 : $signed(32'($urandom)));
        end
        send_word(sdeq_pkg::CMD_PUSH_FRONT, 32'sd1);
        send_word(sdeq_pkg::CMD_PUSH_BACK, 32'sd2);
        send_word(sdeq_pkg::CMD_SORT, 32'sd0);
        send_word(sdeq_pkg::CMD_POP_FRONT, 32'sd0);
        send_word(sdeq_pkg::CMD_POP_BACK, 32'sd0);
    endtask

    // Random commands in fill and empty phases so both ends of the range get hit
    task automatic test_random_traffic();
        bit fill_phase;
        int phase_left;
        int r;
        logic [2:0] cmd;
        fill_phase = 1'b1;
        phase_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % SEGMENT_LEN == 0) begin
                tx_idle = (n == 0) ? 1'b0 : (n == SEGMENT_LEN) ? 1'b1 : 1'($urandom);
                rx_idle = (n == 0) ? 1'b0 : (n == SEGMENT_LEN) ? 1'b1 : 1'($urandom);
            end
            if (phase_left == 0) begin
                fill_phase = ~fill_phase;
                phase_left = $urandom_range(8, 40);
            end
            phase_left--;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                cmd = sdeq_pkg::CMD_SORT;
            end else if (r < 5) begin
                cmd = 3'(sdeq_pkg::CMD_SORT + $urandom_range(1, 3));
            end else if (r < (fill_phase ? 80 : 35)) begin
                cmd = $urandom_range(0, 1) ? sdeq_pkg::CMD_PUSH_FRONT
                                           : sdeq_pkg::CMD_PUSH_BACK;
            end else begin
                cmd = $urandom_range(0, 1) ? sdeq_pkg::CMD_POP_FRONT
                                           : sdeq_pkg::CMD_POP_BACK;
            end
            send_word(cmd, pick_value());
        end
    endtask

    // Hold the output off for a long stretch while commands keep coming
    task automatic test_output_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold_len = 300;
        for (int n = 0; n < 40; n++) begin
            send_word(n[0] ? sdeq_pkg::CMD_PUSH_FRONT : sdeq_pkg::CMD_POP_BACK,
                      pick_value());
        end
    endtask

    // Stop offering until the block has answered everything, then resume
    task automatic test_sender_pause();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (int n = 0; n < 30; n++) begin
            send_word($urandom_range(0, 1) ? sdeq_pkg::CMD_PUSH_BACK
                                           : sdeq_pkg::CMD_POP_FRONT, pick_value());
        end
        wait_for_drain();
        send_word(sdeq_pkg::CMD_SORT, 32'sd0);
        for (int n = 0; n < 30; n++) begin
            send_word(3'($urandom_range(0, 4)), pick_value());
        end
    endtask

    // Result side: random stall before each word, plus a requested long hold
    initial begin : result_sink
        int hold;
        out_stall <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (rx_hold_len > 0) begin
                hold = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                hold = rx_idle ? $urandom_range(0, 8) : 0;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Compare each accepted result word with the oldest pending one
    always @(posedge clk) begin : result_check
        sdeq_pkg::t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("pending results", 32'd0, 32'd1);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (out_word.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(out_word.status));
                if (out_word.popped_value !== want.popped_value)
                    report_mismatch("popped_value", want.popped_value, out_word.popped_value);
                if (out_word.front_value !== want.front_value)
                    report_mismatch("front_value", want.front_value, out_word.front_value);
                if (out_word.back_value !== want.back_value)
                    report_mismatch("back_value", want.back_value, out_word.back_value);
                if (out_word.item_count !== want.item_count)
                    report_mismatch("item_count", 32'(want.item_count),
                                    32'(out_word.item_count));
            end
            checked_count++;
        end
    end

    // Guard against a hung handshake
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sortable_double_ended_queue verification failed");
            $finish;
        end
    end

    initial begin
        in_valid <= 1'b0;
        in_word  <= '0;
        rst_n    <= 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        checked_count = 0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold_len = 0;
        shadow_head = 0;
        shadow_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();

        // let the last results come back, then a short settle
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0) begin
            report_mismatch("leftover results", 32'd0, pending_results.size());
        end
        if (mismatch_count == 0) begin
            $display("sortable_double_ended_queue verification clean");
        end else begin
            $display("sortable_double_ended_queue verification failed");
        end
        $finish;
    end

endmodule
